// ===== rtl/epsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsc_pkg: shared constants and helpers for epoch to calendar conversion
// Field widths, time constants, and the month length table.
// ----------------------------------------------------------------------------
package epsc_pkg;

  // Field widths
  localparam int EpochW  = 31;
  localparam int WorkW   = 32;  // epoch plus zone offset, and shifted divisors
  localparam int YearW   = 11;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int RemW    = 17;  // seconds of the day, below 86400
  localparam int QuoW    = 15;  // day count, below 2^15 for any input
  localparam int StepW   = 4;   // bit position counter of the divide passes

  // Time constants
  localparam int unsigned ZoneOffsetSecs = 28800;
  localparam int unsigned DaySecs        = 86400;
  localparam int unsigned HourSecs       = 3600;
  localparam int unsigned MinuteSecs     = 60;
  localparam int unsigned BaseYear       = 1970;
  localparam int unsigned CommonDays     = 31536000 / DaySecs;
  localparam int unsigned LeapDays       = 31622400 / DaySecs;
  localparam int unsigned LastMonth      = 11;

  // Quotient bits each pass develops
  localparam int HourBits   = HourW;
  localparam int MinuteBits = MinuteW;

  // Leap year test. Across 1970..2038 the only century year is 2000, which
  // is divisible by 400, so divisibility by four settles it.
  function automatic logic is_leap(input logic [YearW-1:0] year);
    is_leap = (year[1:0] == 2'b00);
  endfunction

  // Days in a month, month counted from 0
  function automatic logic [8:0] month_days(input logic [MonthW-1:0] month,
                                            input logic leap);
    logic [8:0] len;
    case (month)
      4'd0:    len = 9'd31;
      4'd1:    len = leap ? 9'd29 : 9'd28;
      4'd2:    len = 9'd31;
      4'd3:    len = 9'd30;
      4'd4:    len = 9'd31;
      4'd5:    len = 9'd30;
      4'd6:    len = 9'd31;
      4'd7:    len = 9'd31;
      4'd8:    len = 9'd30;
      4'd9:    len = 9'd31;
      4'd10:   len = 9'd30;
      4'd11:   len = 9'd31;
      default: len = 9'd31;
    endcase
    month_days = len;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: epoch seconds to UTC+8 calendar date/time
// A small sequencer drives one compare and subtract unit through the day
// divide, year and month walks, and the hour and minute divides.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | epoch_seconds_i
//  out     | output    | out_valid_o / out_stall_i| cal_year_o .. cal_second_o
//
//  The year walk on the shared subtractor dominates the conversion of an item.
//  Reset clears the sequencer and the output valid; nothing else is kept.
//  in_stall_o is high while an item is being converted. A finished result
//  waits in the output register; a new item can be taken while it waits.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [epsc_pkg::EpochW-1:0]  epoch_seconds_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [epsc_pkg::YearW-1:0]   cal_year_o,
  output logic [epsc_pkg::MonthW-1:0]  cal_month_o,
  output logic [epsc_pkg::DayW-1:0]    cal_day_o,
  output logic [epsc_pkg::HourW-1:0]   cal_hour_o,
  output logic [epsc_pkg::MinuteW-1:0] cal_minute_o,
  output logic [epsc_pkg::SecondW-1:0] cal_second_o
);
  import epsc_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DAYS  = 3'd1;
  localparam logic [2:0] S_YEAR  = 3'd2;
  localparam logic [2:0] S_MONTH = 3'd3;
  localparam logic [2:0] S_HOUR  = 3'd4;
  localparam logic [2:0] S_MIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [WorkW-1:0]   num_q, num_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [StepW-1:0]   k_q, k_d;
  logic [YearW-1:0]   year_q, year_d;
  logic [MonthW-1:0]  month_q, month_d;
  logic [DayW-1:0]    day_q, day_d;
  logic [HourW-1:0]   hour_q, hour_d;
  logic [MinuteW-1:0] minute_q, minute_d;
  logic [SecondW-1:0] second_q, second_d;

  logic [YearW-1:0]   oyear_q, oyear_d;
  logic [MonthW-1:0]  omonth_q, omonth_d;
  logic [DayW-1:0]    oday_q, oday_d;
  logic [HourW-1:0]   ohour_q, ohour_d;
  logic [MinuteW-1:0] ominute_q, ominute_d;
  logic [SecondW-1:0] osecond_q, osecond_d;

  logic               leap;
  logic [WorkW-1:0]   op_b;
  logic               ge;
  logic [WorkW-1:0]   diff;
  logic [WorkW-1:0]   step_num;
  logic [QuoW-1:0]    quo_next;
  logic               out_load;

  assign leap     = is_leap(year_q);
  assign step_num = ge ? diff : num_q;
  assign quo_next = {quo_q[QuoW-2:0], ge};
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Divisor for the shared unit
  always_comb begin
    case (state_q)
      S_DAYS:  op_b = WorkW'(DaySecs) << k_q;
      S_YEAR:  op_b = leap ? WorkW'(LeapDays) : WorkW'(CommonDays);
      S_MONTH: op_b = WorkW'(month_days(month_q, leap));
      S_HOUR:  op_b = WorkW'(HourSecs) << k_q;
      S_MIN:   op_b = WorkW'(MinuteSecs) << k_q;
      default: op_b = '0;
    endcase
  end

  epsc_csub u_csub (
    .a_i    (num_q),
    .b_i    (op_b),
    .ge_o   (ge),
    .diff_o (diff)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    k_d         = k_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    second_d    = second_q;
    oyear_d     = oyear_q;
    omonth_d    = omonth_q;
    oday_d      = oday_q;
    ohour_d     = ohour_q;
    ominute_d   = ominute_q;
    osecond_d   = osecond_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          num_d   = WorkW'(epoch_seconds_i) + WorkW'(ZoneOffsetSecs);
          quo_d   = '0;
          k_d     = StepW'(QuoW - 1);
          state_d = S_DAYS;
        end
      end
      // Restoring divide by one day, one quotient bit a cycle
      S_DAYS: begin
        num_d = step_num;
        quo_d = quo_next;
        if (k_q == '0) begin
          rem_d   = step_num[RemW-1:0];
          num_d   = WorkW'(quo_next);
          year_d  = YearW'(BaseYear);
          state_d = S_YEAR;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      // Take whole years off the day count
      S_YEAR: begin
        if (ge) begin
          num_d  = diff;
          year_d = year_q + 1'b1;
        end else begin
          month_d = '0;
          state_d = S_MONTH;
        end
      end
      // Take whole months off; December takes what is left
      S_MONTH: begin
        if (!ge || month_q == MonthW'(LastMonth)) begin
          day_d   = num_q[DayW-1:0] + 1'b1;
          num_d   = WorkW'(rem_q);
          quo_d   = '0;
          k_d     = StepW'(HourBits - 1);
          state_d = S_HOUR;
        end else begin
          num_d   = diff;
          month_d = month_q + 1'b1;
        end
      end
      S_HOUR: begin
        num_d = step_num;
        quo_d = quo_next;
        if (k_q == '0) begin
          hour_d  = quo_next[HourW-1:0];
          quo_d   = '0;
          k_d     = StepW'(MinuteBits - 1);
          state_d = S_MIN;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      S_MIN: begin
        num_d = step_num;
        quo_d = quo_next;
        if (k_q == '0) begin
          minute_d = quo_next[MinuteW-1:0];
          second_d = step_num[SecondW-1:0];
          state_d  = S_DONE;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_load) begin
          oyear_d     = year_q;
          omonth_d    = month_q + 1'b1;
          oday_d      = day_q;
          ohour_d     = hour_q;
          ominute_d   = minute_q;
          osecond_d   = second_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    k_q       <= k_d;
    year_q    <= year_d;
    month_q   <= month_d;
    day_q     <= day_d;
    hour_q    <= hour_d;
    minute_q  <= minute_d;
    second_q  <= second_d;
    oyear_q   <= oyear_d;
    omonth_q  <= omonth_d;
    oday_q    <= oday_d;
    ohour_q   <= ohour_d;
    ominute_q <= ominute_d;
    osecond_q <= osecond_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cal_year_o   = oyear_q;
  assign cal_month_o  = omonth_q;
  assign cal_day_o    = oday_q;
  assign cal_hour_o   = ohour_q;
  assign cal_minute_o = ominute_q;
  assign cal_second_o = osecond_q;

`ifndef NO_ASSERTIONS
  // An accepted item starts the day divide
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_DAYS)
    else $error("accepted item did not start the day divide");

  // Loading the result register always raises valid
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result load did not raise valid");

  // The year walk stays within the input range
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_YEAR |-> year_q <= YearW'(2038))
    else $error("year walk ran past range");

  // The month walk never goes past December
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MONTH |-> month_q <= MonthW'(LastMonth))
    else $error("month walk ran past December");

  // The hour divide never runs more passes than hour bits
  a_hour_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOUR |-> k_q < StepW'(HourBits))
    else $error("hour divide step out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/epsc_csub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsc_csub: shared compare and subtract unit
// Compares the working value against a divisor and gives the difference.
// ----------------------------------------------------------------------------
module epsc_csub (
  input  logic [epsc_pkg::WorkW-1:0] a_i,
  input  logic [epsc_pkg::WorkW-1:0] b_i,
  output logic                       ge_o,
  output logic [epsc_pkg::WorkW-1:0] diff_o
);
  import epsc_pkg::*;

  logic [WorkW:0] sub;

  // One wide subtract; the borrow gives the compare
  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[WorkW];
  assign diff_o = sub[WorkW-1:0];

endmodule
`default_nettype wire
